[src/lobm_pkg.sv]
package lobm_pkg;

	localparam int WORD_BITS = 64;
	localparam int PRICE_W   = 10;
	localparam int QTY_W     = 32;
	localparam int ID_W      = 32;
	localparam int BEST_W    = 11;

	localparam logic [BEST_W-1:0] BEST_NONE = '1;

	typedef enum logic [1:0] {
		OP_BUY    = 2'd0,
		OP_SELL   = 2'd1,
		OP_CANCEL = 2'd2,
		OP_NONE   = 2'd3
	} req_op_t;

	localparam logic [2:0] ST_MORE      = 3'd0;
	localparam logic [2:0] ST_FILLED    = 3'd1;
	localparam logic [2:0] ST_RESTED    = 3'd2;
	localparam logic [2:0] ST_REJECTED  = 3'd3;
	localparam logic [2:0] ST_CANCELLED = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND = 3'd5;

	typedef enum logic [1:0] {
		BM_BEST = 2'd0,
		BM_GET  = 2'd1,
		BM_SET  = 2'd2,
		BM_CLR  = 2'd3
	} bm_op_t;

	typedef struct packed {
		logic               valid;
		bm_op_t             op;
		logic               side;
		logic [PRICE_W-1:0] price;
	} bm_cmd_t;

	typedef struct packed {
		logic               ready;
		logic               done;
		logic               found;
		logic [PRICE_W-1:0] price;
		logic               bit_set;
	} bm_rsp_t;

	typedef struct packed {
		logic                     has_trade;
		logic [ID_W-1:0]          buyer_id;
		logic [ID_W-1:0]          seller_id;
		logic [PRICE_W-1:0]       trade_price;
		logic [QTY_W-1:0]         trade_quantity;
		logic [ID_W-1:0]          request_id;
		logic [2:0]               status;
		logic [QTY_W-1:0]         resting_quantity;
		logic signed [BEST_W-1:0] best_bid;
		logic signed [BEST_W-1:0] best_ask;
		logic                     last;
	} out_row_t;

endpackage

[src/lobm_bitmap.sv]
// Occupancy bitmaps of both sides in one memory, with a word-by-word best price search.
module lobm_bitmap #(
	parameter int MASK_WORDS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lobm_pkg::bm_cmd_t cmd,
	output lobm_pkg::bm_rsp_t rsp
);
	import lobm_pkg::*;

	localparam int WW    = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;
	localparam int DEPTH = 2 * MASK_WORDS;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [3:0] {
		B_CLEAR = 4'b0001,
		B_IDLE  = 4'b0010,
		B_RD    = 4'b0100,
		B_CHK   = 4'b1000
	} bst_t;

	bst_t                 st_q;
	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rd_q;
	logic [AW-1:0]        clr_q;
	bm_op_t               op_q;
	logic                 side_q;
	logic [WW-1:0]        w_q;
	logic [WW-1:0]        cnt_q;
	logic [5:0]           bit_q;
	logic [WW+3:0]        wext;
	logic [AW-1:0]        addr;
	logic [AW-1:0]        waddr;
	logic                 we;
	logic [5:0]           enc;
	logic                 nz;
	logic                 last_word;
	logic [WW+15:0]       pext;
	logic [WORD_BITS-1:0] wdata;

	always_comb begin
		wext      = (WW + 4)'(cmd.price[PRICE_W-1:6]);
		addr      = AW'(w_q) + (side_q ? AW'(MASK_WORDS) : AW'(0));
		nz        = |rd_q;
		last_word = cnt_q == WW'(MASK_WORDS - 1);
		enc       = '0;
		if (!side_q) begin
			for (int i = 0; i < WORD_BITS; i++) begin
				if (rd_q[i]) enc = 6'(i);
			end
		end else begin
			for (int i = WORD_BITS - 1; i >= 0; i--) begin
				if (rd_q[i]) enc = 6'(i);
			end
		end
		pext         = (WW + 16)'({w_q, enc});
		wdata        = rd_q;
		wdata[bit_q] = (op_q == BM_SET);
		we           = (st_q == B_CLEAR) ||
			(st_q == B_CHK && (op_q == BM_SET || op_q == BM_CLR));
		waddr        = (st_q == B_CLEAR) ? clr_q : addr;
	end

	assign rsp.ready   = (st_q == B_IDLE);
	assign rsp.done    = (st_q == B_CHK) && (op_q != BM_BEST || nz || last_word);
	assign rsp.found   = nz;
	assign rsp.price   = pext[PRICE_W-1:0];
	assign rsp.bit_set = rd_q[bit_q];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= (st_q == B_CLEAR) ? '0 : wdata;
		end
		rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= B_CLEAR;
			clr_q  <= '0;
			op_q   <= BM_BEST;
			side_q <= 1'b0;
			w_q    <= '0;
			cnt_q  <= '0;
			bit_q  <= '0;
		end else begin
			case (st_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) st_q <= B_IDLE;
				end
				B_IDLE: begin
					if (cmd.valid) begin
						op_q   <= cmd.op;
						side_q <= cmd.side;
						bit_q  <= cmd.price[5:0];
						cnt_q  <= '0;
						if (cmd.op == BM_BEST) begin
							w_q <= cmd.side ? WW'(0) : WW'(MASK_WORDS - 1);
						end else begin
							w_q <= wext[WW-1:0];
						end
						st_q <= B_RD;
					end
				end
				B_RD: st_q <= B_CHK;
				B_CHK: begin
					if (rsp.done) begin
						st_q <= B_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						w_q   <= side_q ? w_q + 1'b1 : w_q - 1'b1;
						st_q  <= B_RD;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

endmodule

[src/lobm_ctrl.sv]
// Request sequencer: matching walk, level queues, slot pool and cancel search.
module lobm_ctrl #(
	parameter int PRICE_LEVELS  = 1024,
	parameter int MASK_WORDS    = 16,
	parameter int RESTING_SLOTS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  operation,
	input  logic [lobm_pkg::PRICE_W-1:0] limit_price,
	input  logic [lobm_pkg::QTY_W-1:0]   order_quantity,
	input  logic [lobm_pkg::ID_W-1:0]    cancel_id,
	output lobm_pkg::bm_cmd_t           bm_cmd,
	input  lobm_pkg::bm_rsp_t           bm_rsp,
	input  logic                        out_space,
	output logic                        push,
	output lobm_pkg::out_row_t          row
);
	import lobm_pkg::*;

	localparam int SW        = $clog2(RESTING_SLOTS);
	localparam int NW        = $clog2(RESTING_SLOTS + 1);
	localparam int LEVELS    = 2 * PRICE_LEVELS;
	localparam int LW        = $clog2(LEVELS);
	localparam int PRICE_TOP =
		((PRICE_LEVELS < MASK_WORDS * 64) ? PRICE_LEVELS : MASK_WORDS * 64) - 1;

	typedef enum logic [24:0] {
		S_IDLE  = 25'h0000001,
		S_LOOP  = 25'h0000002,
		S_BEST  = 25'h0000004,
		S_BWAIT = 25'h0000008,
		S_HEAD  = 25'h0000010,
		S_SLOT  = 25'h0000020,
		S_PUSH  = 25'h0000040,
		S_FILL  = 25'h0000080,
		S_U1    = 25'h0000100,
		S_U2    = 25'h0000200,
		S_U3    = 25'h0000400,
		S_UCLR  = 25'h0000800,
		S_REST  = 25'h0001000,
		S_GET   = 25'h0002000,
		S_GWAIT = 25'h0004000,
		S_APP   = 25'h0008000,
		S_SETB  = 25'h0010000,
		S_SWAIT = 25'h0020000,
		S_CSCAN = 25'h0040000,
		S_CCMP  = 25'h0080000,
		S_FBID  = 25'h0100000,
		S_FBIDW = 25'h0200000,
		S_FASK  = 25'h0400000,
		S_FASKW = 25'h0800000,
		S_OUT   = 25'h1000000
	} cst_t;

	cst_t st_q;

	// level queues and slot pool
	logic [SW-1:0]    head_mem [LEVELS];
	logic [SW-1:0]    tail_mem [LEVELS];
	logic [ID_W-1:0]  sid_mem  [RESTING_SLOTS];
	logic [LW-1:0]    ssp_mem  [RESTING_SLOTS];
	logic [QTY_W-1:0] srem_mem [RESTING_SLOTS];
	logic [SW-1:0]    snext_mem[RESTING_SLOTS];
	logic [SW-1:0]    sprev_mem[RESTING_SLOTS];

	logic [SW-1:0]    head_rd, tail_rd, snext_rd, sprev_rd;
	logic [ID_W-1:0]  sid_rd;
	logic [LW-1:0]    ssp_rd;
	logic [QTY_W-1:0] srem_rd;

	logic [LW-1:0]    lvl_ra;
	logic [SW-1:0]    slot_ra;
	logic             head_we, tail_we, sid_we, ssp_we, srem_we, snext_we, sprev_we;
	logic [LW-1:0]    head_wa, tail_wa;
	logic [SW-1:0]    head_wd, tail_wd;
	logic [SW-1:0]    slot_wa, snext_wa, sprev_wa, snext_wd, sprev_wd;
	logic [QTY_W-1:0] srem_wd;

	logic [1:0]         op_q;
	logic               side_q;
	logic [PRICE_W-1:0] price_q;
	logic [QTY_W-1:0]   rem_q;
	logic [ID_W-1:0]    cid_q;
	logic [ID_W-1:0]    req_q;
	logic [ID_W-1:0]    next_q;
	logic [NW-1:0]      n_q;
	logic [SW-1:0]      s_q;
	logic [SW-1:0]      cs_q;
	logic [QTY_W-1:0]   srem_q;
	logic [ID_W-1:0]    sidv_q;
	logic [PRICE_W-1:0] bp_q;
	logic [LW-1:0]      ulvl_q;
	logic [SW-1:0]      nx_q;
	logic [SW-1:0]      pv_q;
	logic [2:0]         status_q;
	logic               pend_q;
	logic [ID_W-1:0]    pbuy_q;
	logic [ID_W-1:0]    psell_q;
	logic [PRICE_W-1:0] pprice_q;
	logic [QTY_W-1:0]   pqty_q;
	logic [BEST_W-1:0]  bid_q;
	logic [BEST_W-1:0]  ask_q;
	logic [RESTING_SLOTS-1:0] used_q;

	logic [PRICE_W-1:0] in_price;
	logic [QTY_W-1:0]   fill;
	logic [QTY_W-1:0]   rem_after;
	logic [QTY_W-1:0]   srem_after;
	logic               cross_ok;
	logic [LW-1:0]      bm_lvl;
	logic [LW-1:0]      rlvl;
	logic               uside;
	logic [LW+9:0]      uext;
	logic               free_ok;
	logic [SW-1:0]      free_idx;
	logic               sole;
	logic [BEST_W-1:0]  best_enc;

	always_comb begin
		in_price = limit_price;
		if (int'(limit_price) > PRICE_TOP) in_price = PRICE_W'(PRICE_TOP);
		fill       = (rem_q < srem_q) ? rem_q : srem_q;
		rem_after  = rem_q - fill;
		srem_after = srem_q - fill;
		cross_ok   = side_q ? (bm_rsp.price >= price_q) : (bm_rsp.price <= price_q);
		bm_lvl     = LW'(bm_rsp.price) + (side_q ? LW'(0) : LW'(PRICE_LEVELS));
		rlvl       = LW'(price_q) + (side_q ? LW'(PRICE_LEVELS) : LW'(0));
		uside      = ulvl_q >= LW'(PRICE_LEVELS);
		uext       = (LW + 10)'(ulvl_q - (uside ? LW'(PRICE_LEVELS) : LW'(0)));
		free_ok    = ~&used_q;
		free_idx   = '0;
		for (int i = RESTING_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) free_idx = SW'(i);
		end
		sole     = (head_rd == s_q) && (tail_rd == s_q);
		best_enc = bm_rsp.found ? {1'b0, bm_rsp.price} : BEST_NONE;
	end

	assign in_ready = (st_q == S_IDLE) && bm_rsp.ready;

	// Memory ports and bitmap commands, all decoded from the state.
	always_comb begin
		lvl_ra   = rlvl;
		slot_ra  = s_q;
		head_we  = 1'b0;
		tail_we  = 1'b0;
		sid_we   = 1'b0;
		ssp_we   = 1'b0;
		srem_we  = 1'b0;
		snext_we = 1'b0;
		sprev_we = 1'b0;
		head_wa  = rlvl;
		tail_wa  = rlvl;
		head_wd  = s_q;
		tail_wd  = s_q;
		slot_wa  = s_q;
		snext_wa = s_q;
		sprev_wa = s_q;
		snext_wd = s_q;
		sprev_wd = s_q;
		srem_wd  = rem_q;
		bm_cmd.valid = 1'b0;
		bm_cmd.op    = BM_BEST;
		bm_cmd.side  = side_q;
		bm_cmd.price = price_q;
		case (st_q)
			S_BEST: begin
				bm_cmd.valid = 1'b1;
				bm_cmd.side  = ~side_q;
			end
			S_BWAIT: lvl_ra = bm_lvl;
			S_HEAD:  slot_ra = head_rd;
			S_FILL: begin
				srem_we = 1'b1;
				srem_wd = srem_after;
			end
			S_U2: lvl_ra = ssp_rd;
			S_U3: begin
				if (sole) begin
					bm_cmd.valid = 1'b1;
					bm_cmd.op    = BM_CLR;
					bm_cmd.side  = uside;
					bm_cmd.price = uext[PRICE_W-1:0];
				end else if (head_rd == s_q) begin
					head_we = 1'b1;
					head_wa = ulvl_q;
					head_wd = nx_q;
				end else if (tail_rd == s_q) begin
					tail_we = 1'b1;
					tail_wa = ulvl_q;
					tail_wd = pv_q;
				end else begin
					snext_we = 1'b1;
					snext_wa = pv_q;
					snext_wd = nx_q;
					sprev_we = 1'b1;
					sprev_wa = nx_q;
					sprev_wd = pv_q;
				end
			end
			S_REST: begin
				if (rem_q != '0 && free_ok) begin
					sid_we  = 1'b1;
					ssp_we  = 1'b1;
					srem_we = 1'b1;
					slot_wa = free_idx;
				end
			end
			S_GET: begin
				bm_cmd.valid = 1'b1;
				bm_cmd.op    = BM_GET;
			end
			S_GWAIT: begin
				if (bm_rsp.done && !bm_rsp.bit_set) begin
					head_we  = 1'b1;
					tail_we  = 1'b1;
					snext_we = 1'b1;
					sprev_we = 1'b1;
				end
			end
			S_APP: begin
				snext_we = 1'b1;
				snext_wa = tail_rd;
				sprev_we = 1'b1;
				sprev_wd = tail_rd;
				tail_we  = 1'b1;
			end
			S_SETB: begin
				bm_cmd.valid = 1'b1;
				bm_cmd.op    = BM_SET;
			end
			S_CSCAN: slot_ra = cs_q;
			S_FBID: begin
				bm_cmd.valid = 1'b1;
				bm_cmd.side  = 1'b0;
			end
			S_FASK: begin
				bm_cmd.valid = 1'b1;
				bm_cmd.side  = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_we)  head_mem[head_wa]   <= head_wd;
		if (tail_we)  tail_mem[tail_wa]   <= tail_wd;
		if (sid_we)   sid_mem[slot_wa]    <= req_q;
		if (ssp_we)   ssp_mem[slot_wa]    <= rlvl;
		if (srem_we)  srem_mem[slot_wa]   <= srem_wd;
		if (snext_we) snext_mem[snext_wa] <= snext_wd;
		if (sprev_we) sprev_mem[sprev_wa] <= sprev_wd;
		head_rd  <= head_mem[lvl_ra];
		tail_rd  <= tail_mem[lvl_ra];
		sid_rd   <= sid_mem[slot_ra];
		ssp_rd   <= ssp_mem[slot_ra];
		srem_rd  <= srem_mem[slot_ra];
		snext_rd <= snext_mem[slot_ra];
		sprev_rd <= sprev_mem[slot_ra];
	end

	// Rows to the output register.
	always_comb begin
		push = ((st_q == S_PUSH) || (st_q == S_OUT)) && out_space;
		row.has_trade      = pend_q;
		row.buyer_id       = pend_q ? pbuy_q : '0;
		row.seller_id      = pend_q ? psell_q : '0;
		row.trade_price    = pend_q ? pprice_q : '0;
		row.trade_quantity = pend_q ? pqty_q : '0;
		row.request_id     = req_q;
		row.status         = ST_MORE;
		row.resting_quantity = '0;
		row.best_bid       = '0;
		row.best_ask       = '0;
		row.last           = 1'b0;
		if (st_q == S_OUT) begin
			row.status           = status_q;
			row.resting_quantity = rem_q;
			row.best_bid         = bid_q;
			row.best_ask         = ask_q;
			row.last             = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			used_q   <= '0;
			next_q   <= ID_W'(1);
			op_q     <= '0;
			side_q   <= 1'b0;
			price_q  <= '0;
			rem_q    <= '0;
			cid_q    <= '0;
			req_q    <= '0;
			n_q      <= '0;
			s_q      <= '0;
			cs_q     <= '0;
			srem_q   <= '0;
			sidv_q   <= '0;
			bp_q     <= '0;
			ulvl_q   <= '0;
			nx_q     <= '0;
			pv_q     <= '0;
			status_q <= ST_MORE;
			pend_q   <= 1'b0;
			pbuy_q   <= '0;
			psell_q  <= '0;
			pprice_q <= '0;
			pqty_q   <= '0;
			bid_q    <= '0;
			ask_q    <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						op_q    <= operation;
						side_q  <= operation[0];
						price_q <= in_price;
						cid_q   <= cancel_id;
						pend_q  <= 1'b0;
						n_q     <= '0;
						cs_q    <= '0;
						if (operation == OP_BUY || operation == OP_SELL) begin
							req_q  <= next_q;
							next_q <= next_q + 1'b1;
							rem_q  <= order_quantity;
							if (order_quantity == '0) begin
								status_q <= ST_FILLED;
								st_q     <= S_FBID;
							end else begin
								st_q <= S_LOOP;
							end
						end else begin
							req_q <= cancel_id;
							rem_q <= '0;
							if (operation == OP_CANCEL) begin
								st_q <= S_CSCAN;
							end else begin
								status_q <= ST_NOT_FOUND;
								st_q     <= S_FBID;
							end
						end
					end
				end
				S_LOOP: begin
					if (rem_q == '0 || n_q == NW'(RESTING_SLOTS)) st_q <= S_REST;
					else st_q <= S_BEST;
				end
				S_BEST: st_q <= S_BWAIT;
				S_BWAIT: begin
					if (bm_rsp.done) begin
						if (bm_rsp.found && cross_ok) begin
							bp_q <= bm_rsp.price;
							st_q <= S_HEAD;
						end else begin
							st_q <= S_REST;
						end
					end
				end
				S_HEAD: begin
					s_q  <= head_rd;
					st_q <= S_SLOT;
				end
				S_SLOT: begin
					srem_q <= srem_rd;
					sidv_q <= sid_rd;
					st_q   <= pend_q ? S_PUSH : S_FILL;
				end
				S_PUSH: begin
					if (out_space) begin
						pend_q <= 1'b0;
						st_q   <= S_FILL;
					end
				end
				S_FILL: begin
					rem_q    <= rem_after;
					pend_q   <= 1'b1;
					pbuy_q   <= side_q ? sidv_q : req_q;
					psell_q  <= side_q ? req_q : sidv_q;
					pprice_q <= bp_q;
					pqty_q   <= fill;
					n_q      <= n_q + 1'b1;
					st_q     <= (srem_after == '0) ? S_U1 : S_LOOP;
				end
				S_U1: st_q <= S_U2;
				S_U2: begin
					ulvl_q <= ssp_rd;
					nx_q   <= snext_rd;
					pv_q   <= sprev_rd;
					st_q   <= S_U3;
				end
				S_U3: begin
					used_q[s_q] <= 1'b0;
					if (sole) begin
						st_q <= S_UCLR;
					end else if (op_q == OP_CANCEL) begin
						status_q <= ST_CANCELLED;
						st_q     <= S_FBID;
					end else begin
						st_q <= S_LOOP;
					end
				end
				S_UCLR: begin
					if (bm_rsp.done) begin
						if (op_q == OP_CANCEL) begin
							status_q <= ST_CANCELLED;
							st_q     <= S_FBID;
						end else begin
							st_q <= S_LOOP;
						end
					end
				end
				S_REST: begin
					if (rem_q == '0) begin
						status_q <= ST_FILLED;
						st_q     <= S_FBID;
					end else if (!free_ok) begin
						status_q <= ST_REJECTED;
						st_q     <= S_FBID;
					end else begin
						used_q[free_idx] <= 1'b1;
						s_q              <= free_idx;
						st_q             <= S_GET;
					end
				end
				S_GET: st_q <= S_GWAIT;
				S_GWAIT: begin
					if (bm_rsp.done) st_q <= bm_rsp.bit_set ? S_APP : S_SETB;
				end
				S_APP: begin
					status_q <= ST_RESTED;
					st_q     <= S_FBID;
				end
				S_SETB: st_q <= S_SWAIT;
				S_SWAIT: begin
					if (bm_rsp.done) begin
						status_q <= ST_RESTED;
						st_q     <= S_FBID;
					end
				end
				S_CSCAN: st_q <= S_CCMP;
				S_CCMP: begin
					if (used_q[cs_q] && sid_rd == cid_q) begin
						s_q  <= cs_q;
						st_q <= S_U1;
					end else if (cs_q == SW'(RESTING_SLOTS - 1)) begin
						status_q <= ST_NOT_FOUND;
						st_q     <= S_FBID;
					end else begin
						cs_q <= cs_q + 1'b1;
						st_q <= S_CSCAN;
					end
				end
				S_FBID: st_q <= S_FBIDW;
				S_FBIDW: begin
					if (bm_rsp.done) begin
						bid_q <= best_enc;
						st_q  <= S_FASK;
					end
				end
				S_FASK: st_q <= S_FASKW;
				S_FASKW: begin
					if (bm_rsp.done) begin
						ask_q <= best_enc;
						st_q  <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_space) st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

[src/limit_order_book_matcher.sv]
// Price-time priority limit order book with a fixed pool of resting orders.
// The slave stream takes one request item: add buy, add sell or cancel. An add gets
// the next sequential id and is matched against the opposite side, best price first
// and oldest order first within a price; each fill leaves as one result item, and the
// final item of the request (tlast high) also carries the status, the remainder and
// the best bid and ask after the request. A cancel answers with exactly one item.
// One request is worked at a time and s_tready stays low until its final item has
// been loaded into the output register. The time per request depends on the book:
// each best price search reads up to MASK_WORDS bitmap words of a side, one at a
// time in a read and a check state, each fill adds its queue reads and updates to
// the search, and a cancel scans the slot pool one slot at a time. The final best
// bid and ask searches add to every request. The bitmap memory and its search unit
// set the pace. After reset the block clears all 2*MASK_WORDS words of its bitmap
// memory, one word a cycle; s_tready stays low meanwhile. Ids restart at one.
// A stalled master side simply holds the result register; the sequencer waits for
// room before it loads the next item, so no result is lost or repeated.
module limit_order_book_matcher #(
	parameter int PRICE_LEVELS  = 1024,
	parameter int MASK_WORDS    = 16,
	parameter int RESTING_SLOTS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// operation[1:0], limit_price[11:2], order_quantity[43:12], cancel_id[75:44]
	input  logic [79:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// buyer_id[31:0], seller_id[63:32], trade_price[73:64], trade_quantity[105:74],
	// request_id[137:106], status[140:138], resting_quantity[172:141],
	// best_bid[183:173], best_ask[194:184]
	output logic [199:0] m_tdata,
	// has_trade[0]
	output logic         m_tuser,
	output logic         m_tlast
);
	import lobm_pkg::*;

	bm_cmd_t  bm_cmd;
	bm_rsp_t  bm_rsp;
	out_row_t row;
	out_row_t out_q;
	logic     ov_q;
	logic     push;
	logic     out_space;

	assign out_space = !ov_q || m_tready;

	lobm_bitmap #(
		.MASK_WORDS(MASK_WORDS)
	) u_bitmap (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (bm_cmd),
		.rsp   (bm_rsp)
	);

	lobm_ctrl #(
		.PRICE_LEVELS (PRICE_LEVELS),
		.MASK_WORDS   (MASK_WORDS),
		.RESTING_SLOTS(RESTING_SLOTS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.operation     (s_tdata[1:0]),
		.limit_price   (s_tdata[11:2]),
		.order_quantity(s_tdata[43:12]),
		.cancel_id     (s_tdata[75:44]),
		.bm_cmd        (bm_cmd),
		.bm_rsp        (bm_rsp),
		.out_space     (out_space),
		.push          (push),
		.row           (row)
	);

	// Output register: loaded whenever it is empty or being emptied in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (push) begin
			ov_q <= 1'b1;
		end else if (m_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) out_q <= row;
	end

	assign m_tvalid = ov_q;
	assign m_tuser  = out_q.has_trade;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {5'b0, out_q.best_ask, out_q.best_bid, out_q.resting_quantity,
		out_q.status, out_q.request_id, out_q.trade_quantity, out_q.trade_price,
		out_q.seller_id, out_q.buyer_id};

	// The sequencer only loads a result when the register has room.
	assert property (@(posedge clk) disable iff (!arst_n) push |-> out_space)
		else $error("result loaded into a full output register");

	// An accepted request keeps the block busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while another is in progress");

	// Only the final item of a request carries a non-zero status.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[140:138] != ST_MORE)))
		else $error("status and last marker disagree");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import lobm_pkg::*;

	localparam int SLOTS      = 64;
	localparam int IDLE_LIMIT = 20000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// operation[1:0], limit_price[11:2], order_quantity[43:12], cancel_id[75:44]
	logic [79:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	// buyer_id, seller_id, trade_price, trade_quantity, request_id, status,
	// resting_quantity, best_bid, best_ask, from the lowest bit up
	logic [199:0] m_tdata;
	// has_trade
	logic         m_tuser;
	logic         m_tlast;

	limit_order_book_matcher DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	// The book as the testbench believes it to be.
	logic            slot_busy [0:SLOTS-1];
	logic [ID_W-1:0] slot_id [0:SLOTS-1];
	logic            slot_ask [0:SLOTS-1];
	logic [9:0]      slot_px [0:SLOTS-1];
	logic [31:0]     slot_qty [0:SLOTS-1];
	int unsigned     slot_age [0:SLOTS-1];
	int unsigned     age_counter;
	logic [ID_W-1:0] next_id;

	out_row_t expected_rows[$];
	int unsigned errors;
	int unsigned idle_cycles;
	bit hold_off;
	logic [ID_W-1:0] recent_ids[$];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Recomputes the best price of one side from the slots themselves.
	function automatic logic signed [10:0] best_price(input logic ask);
		int best;
		best = -1;
		for (int s = 0; s < SLOTS; s++) begin
			if (slot_busy[s] && slot_ask[s] == ask) begin
				if (best < 0 || (ask ? slot_px[s] < best : slot_px[s] > best)) begin
					best = slot_px[s];
				end
			end
		end
		return 11'(best);
	endfunction

	// Oldest order resting at a given side and price, or -1.
	function automatic int oldest_at(input logic ask, input logic [9:0] px);
		int pick;
		pick = -1;
		for (int s = 0; s < SLOTS; s++) begin
			if (slot_busy[s] && slot_ask[s] == ask && slot_px[s] == px) begin
				if (pick < 0 || slot_age[s] < slot_age[pick]) begin
					pick = s;
				end
			end
		end
		return pick;
	endfunction

	// Works out every result row that one request causes, in order.
	task automatic predict_book(input logic [1:0] op, input logic [9:0] px,
			input logic [31:0] qty, input logic [31:0] cid);
		out_row_t row;
		logic [ID_W-1:0] req;
		logic [31:0] rem, fill;
		logic signed [10:0] bp;
		logic side;
		int n, s;
		row = '0;
		if (op == OP_CANCEL || op == OP_NONE) begin
			row.request_id = cid;
			row.status = ST_NOT_FOUND;
			if (op == OP_CANCEL) begin
				for (s = 0; s < SLOTS; s++) begin
					if (slot_busy[s] && slot_id[s] == cid) begin
						slot_busy[s] = 1'b0;
						row.status = ST_CANCELLED;
						break;
					end
				end
			end
			row.best_bid = best_price(1'b0);
			row.best_ask = best_price(1'b1);
			row.last = 1'b1;
			expected_rows = {expected_rows, row};
			return;
		end
		side = op[0];
		req = next_id;
		next_id = next_id + 1'b1;
		recent_ids = {recent_ids, req};
		if (recent_ids.size() > 40) recent_ids.delete(0);
		rem = qty;
		n = 0;
		while (rem > 0 && n < SLOTS) begin
			bp = best_price(~side);
			if (bp < 0) break;
			if (side == 1'b0 ? bp[9:0] > px : bp[9:0] < px) break;
			s = oldest_at(~side, bp[9:0]);
			fill = rem < slot_qty[s] ? rem : slot_qty[s];
			rem -= fill;
			slot_qty[s] -= fill;
			if (n > 0) expected_rows = {expected_rows, row};
			row = '0;
			row.has_trade = 1'b1;
			row.buyer_id = side == 1'b0 ? req : slot_id[s];
			row.seller_id = side == 1'b0 ? slot_id[s] : req;
			row.trade_price = bp[9:0];
			row.trade_quantity = fill;
			row.request_id = req;
			n++;
			if (slot_qty[s] == 0) slot_busy[s] = 1'b0;
		end
		if (rem == 0) begin
			row.status = ST_FILLED;
		end else begin
			for (s = 0; s < SLOTS && slot_busy[s]; s++) begin
			end
			if (s < SLOTS) begin
				slot_busy[s] = 1'b1;
				slot_id[s] = req;
				slot_ask[s] = side;
				slot_px[s] = px;
				slot_qty[s] = rem;
				slot_age[s] = age_counter++;
				row.status = ST_RESTED;
			end else begin
				row.status = ST_REJECTED;
			end
		end
		row.request_id = req;
		row.resting_quantity = rem;
		row.best_bid = best_price(1'b0);
		row.best_ask = best_price(1'b1);
		row.last = 1'b1;
		expected_rows = {expected_rows, row};
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Sends one request item after a random gap, and updates the prediction.
	// With no gap the valid line stays high straight into the next item.
	task automatic send_request(input logic [1:0] op, input logic [9:0] px,
			input logic [31:0] qty, input logic [31:0] cid);
		int gap;
		gap = $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= {4'b0, cid, qty, px, op};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_book(op, px, qty, cid);
		@(negedge clk);
	endtask

	task automatic wait_drained;
		s_tvalid <= 1'b0;
		while (expected_rows.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		@(negedge clk);
	endtask

	// Receiver: random stalls, and a long hold-off when asked.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Each accepted result item is compared with the oldest expectation.
	initial begin
		out_row_t want;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (expected_rows.size() == 0) begin
					report_mismatch("unexpected result item", 64'(m_tdata[137:106]),
						64'd0);
				end else begin
					want = expected_rows[0];
					expected_rows.delete(0);
					if (m_tuser !== want.has_trade)
						report_mismatch("has_trade", 64'(m_tuser), 64'(want.has_trade));
					if (m_tdata[31:0] !== want.buyer_id)
						report_mismatch("buyer_id", 64'(m_tdata[31:0]), 64'(want.buyer_id));
					if (m_tdata[63:32] !== want.seller_id)
						report_mismatch("seller_id", 64'(m_tdata[63:32]),
							64'(want.seller_id));
					if (m_tdata[73:64] !== want.trade_price)
						report_mismatch("trade_price", 64'(m_tdata[73:64]),
							64'(want.trade_price));
					if (m_tdata[105:74] !== want.trade_quantity)
						report_mismatch("trade_quantity", 64'(m_tdata[105:74]),
							64'(want.trade_quantity));
					if (m_tdata[137:106] !== want.request_id)
						report_mismatch("request_id", 64'(m_tdata[137:106]),
							64'(want.request_id));
					if (m_tdata[140:138] !== want.status)
						report_mismatch("status", 64'(m_tdata[140:138]), 64'(want.status));
					if (m_tdata[172:141] !== want.resting_quantity)
						report_mismatch("resting_quantity", 64'(m_tdata[172:141]),
							64'(want.resting_quantity));
					if (m_tdata[183:173] !== want.best_bid)
						report_mismatch("best_bid", 64'(m_tdata[183:173]),
							64'(want.best_bid));
					if (m_tdata[194:184] !== want.best_ask)
						report_mismatch("best_ask", 64'(m_tdata[194:184]),
							64'(want.best_ask));
					if (m_tlast !== want.last)
						report_mismatch("last", 64'(m_tlast), 64'(want.last));
				end
			end
		end
	end

	// Watchdog: the run ends if nothing moves for too long.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Edge prices and quantities, zero quantity, crossing at each side,
	// cancels hit and missed, and the unused operation code.
	task automatic test_directed;
		send_request(OP_BUY, 10'd0, 32'd0, 32'd0);
		send_request(OP_BUY, 10'd100, 32'd50, 32'hFFFF_FFFF);
		send_request(OP_BUY, 10'd100, 32'd30, 32'd0);
		send_request(OP_SELL, 10'd1023, 32'hFFFF_FFFF, 32'd0);
		send_request(OP_SELL, 10'd90, 32'd60, 32'd0);
		send_request(OP_SELL, 10'd0, 32'd10, 32'd0);
		send_request(OP_BUY, 10'd1023, 32'd5, 32'd0);
		send_request(OP_CANCEL, 10'd0, 32'd0, 32'd3);
		send_request(OP_CANCEL, 10'd0, 32'd0, 32'd3);
		send_request(OP_CANCEL, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_NONE, 10'h3FF, 32'hFFFF_FFFF, 32'h1234_5678);
		send_request(OP_BUY, 10'd0, 32'hFFFF_FFFF, 32'd0);
		send_request(OP_SELL, 10'd0, 32'hFFFF_FFFF, 32'd0);
		wait_drained();
	endtask

	// Fill the pool to the brim so that remainders are rejected, then sweep
	// many resting orders with one aggressive order.
	task automatic test_pool_full;
		for (int i = 0; i < SLOTS + 2; i++)
			send_request(OP_BUY, 10'($urandom_range(0, 20)), 32'($urandom_range(1, 9)),
				32'd0);
		send_request(OP_SELL, 10'd0, 32'hFFFF_FFFF, 32'd0);
		send_request(OP_BUY, 10'd1023, 32'hFFFF_FFFF, 32'd0);
		wait_drained();
	endtask

	// The receiver stops for a long while so the block backs up onto its input.
	task automatic test_backpressure;
		hold_off = 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 8; i++)
				send_request(2'(i % 2), 10'(500 + i % 3), 32'($urandom_range(1, 9)),
					32'd0);
		join
		wait_drained();
	endtask

	// Random traffic, mostly around a narrow price band, with cancels of recent ids.
	task automatic test_random;
		logic [1:0] op;
		logic [31:0] cid;
		logic [9:0] px;
		logic [31:0] qty;
		int r;
		for (int i = 0; i < 131; i++) begin
			r = $urandom_range(0, 99);
			cid = $urandom;
			if (r < 40) op = OP_BUY;
			else if (r < 80) op = OP_SELL;
			else if (r < 97) begin
				op = OP_CANCEL;
				if (recent_ids.size() > 0 && $urandom_range(0, 3) != 0)
					cid = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
			end else op = OP_NONE;
			px = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(490, 510));
			qty = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 40));
			send_request(op, px, qty, cid);
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		hold_off = 1'b0;
		errors = 0;
		next_id = 1;
		age_counter = 0;
		for (int s = 0; s < SLOTS; s++) slot_busy[s] = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_pool_full();
		test_backpressure();
		test_random();
		if (errors == 0 && expected_rows.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[files.f]
src/lobm_pkg.sv
src/lobm_bitmap.sv
src/lobm_ctrl.sv
src/limit_order_book_matcher.sv
tb/testbench.sv
